>>> hdl/ordered_keyed_list_engine_assert.svh
// assertion macros used by the list engine sequencer
`ifndef ORDERED_KEYED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_KEYED_LIST_ENGINE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define OKLE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define OKLE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define OKLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/okle_pkg.sv
// shared types and constants of the ordered keyed list engine
package okle_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int REQ_W    = 3;
    localparam int KEY_W    = 32;
    localparam int DATA_W   = 32;
    localparam int ST_W     = 2;
    localparam int OCNT_W   = 6;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_HEAD  = 3'd0,
        REQ_INS_TAIL  = 3'd1,
        REQ_REM_FIRST = 3'd2,
        REQ_REM_LAST  = 3'd3,
        REQ_REM_KEY   = 3'd4,
        REQ_FIND      = 3'd5,
        REQ_REPLACE   = 3'd6
    } req_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic              valid;
        status_t           status;
        entry_t            entry;
        logic [OCNT_W-1:0] count;
    } resp_t;

endpackage

>>> hdl/okle_store.sv
// entry store: one write port, one read port with registered read data
module okle_store (
    input  logic               clk,
    input  okle_pkg::mem_req_t mem_req,
    output okle_pkg::entry_t   rdata
);
    import okle_pkg::*;

    logic [ENTRY_W-1:0] mem [CAPACITY];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        rdata_reg <= mem[mem_req.raddr];
    end

    assign rdata = entry_t'(rdata_reg);

endmodule

>>> hdl/okle_ctrl.sv
// request sequencer: walks the store one entry at a time with a single key comparator
`include "ordered_keyed_list_engine_assert.svh"

module okle_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [okle_pkg::REQ_W-1:0]   req_type,
    input  logic [okle_pkg::KEY_W-1:0]   match_key,
    input  logic [okle_pkg::KEY_W-1:0]   item_key,
    input  logic [okle_pkg::DATA_W-1:0]  item_data,
    output okle_pkg::mem_req_t           mem_req,
    input  okle_pkg::entry_t             rd_entry,
    output okle_pkg::resp_t              resp,
    input  logic                         resp_ack
);
    import okle_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD_RD,
        S_HEAD_WR,
        S_HEAD_PUT,
        S_TAIL,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DN_RD,
        S_DN_WR,
        S_LAST_RD,
        S_LAST_GET,
        S_DONE
    } state_t;

    state_t             state_reg,  state_next;
    logic [CNT_W-1:0]   ptr_reg,    ptr_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [REQ_W-1:0]   req_reg,    req_next;
    logic [KEY_W-1:0]   mkey_reg,   mkey_next;
    entry_t             item_reg,   item_next;
    status_t            status_reg, status_next;
    entry_t             found_reg,  found_next;

    logic [CNT_W-1:0]   ptr_inc;
    logic [CNT_W-1:0]   ptr_inc2;
    logic               hit;

    assign ptr_inc  = ptr_reg + 1'b1;
    assign ptr_inc2 = ptr_reg + CNT_W'(2);
    // shared comparator; remove first takes the head entry unconditionally
    assign hit      = (req_reg == REQ_REM_FIRST) || (rd_entry.key == mkey_reg);

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        req_next      = req_reg;
        mkey_next     = mkey_reg;
        item_next     = item_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        in_ready      = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = ptr_reg[IDX_W-1:0];
        mem_req.wdata = rd_entry;
        mem_req.raddr = ptr_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next    = req_type;
                    mkey_next   = match_key;
                    item_next   = '{key: item_key, data: item_data};
                    status_next = ST_OK;
                    found_next  = '0;
                    ptr_next    = '0;
                    state_next  = S_DONE;
                    unique case (req_type)
                        REQ_INS_HEAD:
                        begin
                            if (cnt_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (cnt_reg == '0)
                            begin
                                state_next = S_HEAD_PUT;
                            end
                            else
                            begin
                                ptr_next   = cnt_reg;
                                state_next = S_HEAD_RD;
                            end
                        end
                        REQ_INS_TAIL:
                        begin
                            if (cnt_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_TAIL;
                            end
                        end
                        REQ_REM_FIRST:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        REQ_REM_LAST:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = cnt_reg - 1'b1;
                                state_next = S_LAST_RD;
                            end
                        end
                        REQ_REM_KEY, REQ_FIND, REQ_REPLACE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_HEAD_RD:
            begin
                mem_req.raddr = IDX_W'(ptr_reg - 1'b1);
                state_next    = S_HEAD_WR;
            end
            S_HEAD_WR:
            begin
                mem_req.we = 1'b1;
                ptr_next   = ptr_reg - 1'b1;
                state_next = (ptr_reg == CNT_W'(1)) ? S_HEAD_PUT : S_HEAD_RD;
            end
            S_HEAD_PUT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = '0;
                mem_req.wdata = item_reg;
                cnt_next      = cnt_reg + 1'b1;
                state_next    = S_DONE;
            end
            S_TAIL:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_reg[IDX_W-1:0];
                mem_req.wdata = item_reg;
                cnt_next      = cnt_reg + 1'b1;
                state_next    = S_DONE;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (hit)
                begin
                    found_next = rd_entry;
                    if (req_reg == REQ_REPLACE)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.wdata = item_reg;
                        state_next    = S_DONE;
                    end
                    else if (req_reg == REQ_FIND)
                    begin
                        state_next = S_DONE;
                    end
                    else if (ptr_inc == cnt_reg)
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DN_RD;
                    end
                end
                else if (ptr_inc == cnt_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_SCAN_RD;
                end
            end
            S_DN_RD:
            begin
                mem_req.raddr = ptr_inc[IDX_W-1:0];
                state_next    = S_DN_WR;
            end
            S_DN_WR:
            begin
                mem_req.we = 1'b1;
                ptr_next   = ptr_inc;
                if (ptr_inc2 == cnt_reg)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end
            S_LAST_RD:
            begin
                state_next = S_LAST_GET;
            end
            S_LAST_GET:
            begin
                found_next = rd_entry;
                cnt_next   = cnt_reg - 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (resp_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ptr_reg    <= '0;
            cnt_reg    <= '0;
            req_reg    <= '0;
            mkey_reg   <= '0;
            item_reg   <= '0;
            status_reg <= ST_OK;
            found_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            cnt_reg    <= cnt_next;
            req_reg    <= req_next;
            mkey_reg   <= mkey_next;
            item_reg   <= item_next;
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

    assign resp.valid  = (state_reg == S_DONE);
    assign resp.status = status_reg;
    assign resp.entry  = found_reg;
    assign resp.count  = OCNT_W'(cnt_reg);

    `OKLE_ASSERT_ALWAYS(a_cnt_in_range, cnt_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `OKLE_ASSERT_IMPL(a_wr_in_list, mem_req.we, CNT_W'(mem_req.waddr) <= cnt_reg, "store write beyond list end")
    `OKLE_ASSERT_NEXT(a_cnt_step, 1'b1, (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + 1'b1) || (cnt_reg == $past(cnt_reg) - 1'b1), "entry count moved by more than one")
    `OKLE_ASSERT_IMPL(a_ack_when_done, resp_ack, state_reg == S_DONE, "result taken outside done state")

endmodule

>>> hdl/ordered_keyed_list_engine.sv
// top level of the ordered keyed list engine: sequencer, entry store, result register
//
//  channel   dir  handshake             payload
//  request   in   in_valid / in_ready   req_type, match_key, item_key, item_data
//  result    out  out_valid / out_ready status, out_key, out_data, entry_count
//
// one request at a time; in_ready is high only while the sequencer is idle
// each store step presents an address, then uses the registered read data
// removals shift the entries behind the removed one down by one place
// reset clears the count and the control state; the store itself needs no clearing
// a waiting result sits in the output register, so a new request transfer can
//   start while the previous result is still stalled
module ordered_keyed_list_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [okle_pkg::REQ_W-1:0]          req_type,
    input  logic signed [okle_pkg::KEY_W-1:0]   match_key,
    input  logic signed [okle_pkg::KEY_W-1:0]   item_key,
    input  logic [okle_pkg::DATA_W-1:0]         item_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [okle_pkg::ST_W-1:0]           status,
    output logic signed [okle_pkg::KEY_W-1:0]   out_key,
    output logic [okle_pkg::DATA_W-1:0]         out_data,
    output logic [okle_pkg::OCNT_W-1:0]         entry_count
);
    import okle_pkg::*;

    mem_req_t           mem_req;
    entry_t             rd_entry;
    resp_t              resp;
    logic               resp_ack;

    // result register
    logic               out_valid_reg;
    logic [ST_W-1:0]    status_reg;
    logic [KEY_W-1:0]   out_key_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic [OCNT_W-1:0]  count_reg;

    okle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .match_key (match_key),
        .item_key  (item_key),
        .item_data (item_data),
        .mem_req   (mem_req),
        .rd_entry  (rd_entry),
        .resp      (resp),
        .resp_ack  (resp_ack)
    );

    okle_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rd_entry)
    );

    // the result slot takes a new result when empty or when its transfer completes
    assign resp_ack = resp.valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            out_key_reg   <= '0;
            out_data_reg  <= '0;
            count_reg     <= '0;
        end
        else if (resp_ack)
        begin
            out_valid_reg <= 1'b1;
            status_reg    <= resp.status;
            out_key_reg   <= resp.entry.key;
            out_data_reg  <= resp.entry.data;
            count_reg     <= resp.count;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_key     = out_key_reg;
    assign out_data    = out_data_reg;
    assign entry_count = count_reg;

endmodule
